// File: hw/rtl/rsq_pkg.sv
// ----------------------------------------------------------------------------
// rsq_pkg
// Shared types and constants for the roulette selector with pick quota.
// ----------------------------------------------------------------------------
package rsq_pkg;

  localparam int MAX_ENTRIES_DEF  = 64;
  localparam int FITNESS_BITS_DEF = 24;
  localparam int RANDOM_BITS_DEF  = 16;

  localparam int QUOTA_W = 7;   // pick_quota register width
  localparam int SEL_W   = 6;   // selected_index port width
  localparam int CMD_W   = 2;

  typedef enum logic [CMD_W-1:0] {
    CMD_CLEAR = 2'd0,
    CMD_LOAD  = 2'd1,
    CMD_DRAW  = 2'd2
  } cmd_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_SCAN,
    ST_UPD,
    ST_RESP
  } state_t;

  typedef enum logic {
    ALU_ADD,
    ALU_SUB
  } alu_op_t;

endpackage

// File: hw/rtl/rsq_alu.sv
// ----------------------------------------------------------------------------
// rsq_alu
// Shared add/subtract unit: multiply steps, scan accumulation, sum updates.
// ----------------------------------------------------------------------------
module rsq_alu #(
  parameter int W = 46
) (
  input  rsq_pkg::alu_op_t op,
  input  logic [W-1:0]     a,
  input  logic [W-1:0]     b,
  output logic [W-1:0]     y
);

  logic [W-1:0] b_eff;

  always_comb begin
    case (op)
      rsq_pkg::ALU_SUB: b_eff = ~b;
      default:          b_eff = b;
    endcase
  end

  // subtract as a + ~b + 1
  assign y = a + b_eff + W'(op == rsq_pkg::ALU_SUB);

endmodule

// File: hw/rtl/rsq_table.sv
// ----------------------------------------------------------------------------
// rsq_table
// Entry table: one write port, one registered read port.
// ----------------------------------------------------------------------------
module rsq_table #(
  parameter int DEPTH = 64,
  parameter int W     = 32,
  parameter int AW    = 6
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [W-1:0]  wdata,
  input  logic          re,
  input  logic [AW-1:0] raddr,
  output logic [W-1:0]  rdata
);

  logic [W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: hw/rtl/roulette_select_with_quota.sv
// ----------------------------------------------------------------------------
// roulette_select_with_quota
// Sequence: clear, load and unused commands go from IDLE to RESP and on into the
//   output register; a draw runs MUL over the multiplier bits, SCAN up to the
//   pick, UPD on a hit, then RESP, which waits for a free output register.
// Throughput: one item at a time, in_ready only while idle; draw time is the
//   bit-serial scaling plus a one-entry-per-cycle scan on the one shared adder.
// Reset (rst, synchronous, active high): table empty, sum and quota zero.
// ----------------------------------------------------------------------------
module roulette_select_with_quota #(
  parameter int MAX_ENTRIES  = rsq_pkg::MAX_ENTRIES_DEF,
  parameter int FITNESS_BITS = rsq_pkg::FITNESS_BITS_DEF,
  parameter int RANDOM_BITS  = rsq_pkg::RANDOM_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  // command items
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [rsq_pkg::CMD_W-1:0]    cmd,
  input  logic [FITNESS_BITS-1:0]      fitness,
  input  logic [RANDOM_BITS-1:0]       random_fraction,
  // result items
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [rsq_pkg::SEL_W-1:0]    selected_index,
  output logic                         selected_valid,
  output logic                         entry_retired,
  output logic                         table_full,
  // quota register write
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [rsq_pkg::QUOTA_W-1:0]  pick_quota
);

  localparam int IDX_W  = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int CNT_W  = $clog2(MAX_ENTRIES + 1);
  // MAX_ENTRIES values below 2^FITNESS_BITS each stay under 2^(F+IDX_W)
  localparam int SUM_W  = FITNESS_BITS + IDX_W;
  localparam int ACC_W  = SUM_W + RANDOM_BITS;
  localparam int MC_W   = $clog2(RANDOM_BITS);
  // pick count must hold any limit: quota register or entry count
  localparam int PICK_W = (CNT_W > rsq_pkg::QUOTA_W) ? CNT_W : rsq_pkg::QUOTA_W;
  localparam int MEM_W  = 1 + PICK_W + FITNESS_BITS;

  // --------------------------------------------------------------------------
  // State
  // --------------------------------------------------------------------------
  rsq_pkg::state_t state, state_next;

  logic [rsq_pkg::QUOTA_W-1:0] quota;
  logic [CNT_W-1:0]            entry_count;   // fill count; entries past it are dead
  logic [SUM_W-1:0]            fitness_sum;   // sum over active entries

  // draw working registers
  logic [RANDOM_BITS-1:0]      frac_r;
  logic [ACC_W-1:0]            acc;           // serial product frac * sum
  logic [MC_W-1:0]             mcnt;          // multiplier bit, MSB first
  logic [SUM_W-1:0]            target;
  logic [SUM_W-1:0]            run;           // running fitness total
  logic [CNT_W-1:0]            ridx;          // next table address to read
  logic                        dv;            // read data in flight is valid
  logic [IDX_W-1:0]            didx;          // index of the read data
  logic [IDX_W-1:0]            hit_idx;
  logic [PICK_W-1:0]           hit_cnt;
  logic [FITNESS_BITS-1:0]     hit_fit;

  // pending result
  logic [IDX_W-1:0]            res_idx;
  logic                        res_valid;
  logic                        res_ret;
  logic                        res_full;

  // --------------------------------------------------------------------------
  // Shared adder and table
  // --------------------------------------------------------------------------
  rsq_pkg::alu_op_t alu_op;
  logic [ACC_W-1:0] alu_a, alu_b, alu_y;

  rsq_alu #(.W(ACC_W)) u_alu (
    .op (alu_op),
    .a  (alu_a),
    .b  (alu_b),
    .y  (alu_y)
  );

  logic             mem_we, mem_re;
  logic [IDX_W-1:0] mem_waddr, mem_raddr;
  logic [MEM_W-1:0] mem_wdata, mem_rdata;

  // entry word: {active, pick count, fitness}
  rsq_table #(.DEPTH(MAX_ENTRIES), .W(MEM_W), .AW(IDX_W)) u_table (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  logic [FITNESS_BITS-1:0] rd_fit;
  logic [PICK_W-1:0]       rd_cnt;
  logic                    rd_active;

  assign rd_fit    = mem_rdata[FITNESS_BITS-1:0];
  assign rd_cnt    = mem_rdata[FITNESS_BITS +: PICK_W];
  assign rd_active = mem_rdata[MEM_W-1];

  // --------------------------------------------------------------------------
  // Decode
  // --------------------------------------------------------------------------
  rsq_pkg::cmd_t in_cmd;
  logic          accept;
  logic          full;
  logic          out_slot;      // output register free or emptying now
  logic          hit;
  logic          more;          // entries left to read
  logic [PICK_W:0] cnt_inc;
  logic [PICK_W:0] limit;
  logic          retire;
  logic          load_ok;

  assign in_cmd    = rsq_pkg::cmd_t'(cmd);
  assign in_ready  = (state == rsq_pkg::ST_IDLE);
  assign accept    = in_valid && in_ready;
  assign cfg_ready = 1'b1;
  assign full      = (entry_count == CNT_W'(MAX_ENTRIES));
  assign out_slot  = !out_valid || out_ready;
  assign more      = (ridx < entry_count);
  assign load_ok   = (in_cmd == rsq_pkg::CMD_LOAD) && !full;

  // quota 0 means the number of entries loaded since clear
  assign cnt_inc = {1'b0, hit_cnt} + (PICK_W+1)'(1);
  assign limit   = (quota != '0)
                 ? {{(PICK_W+1-rsq_pkg::QUOTA_W){1'b0}}, quota}
                 : {{(PICK_W+1-CNT_W){1'b0}}, entry_count};
  assign retire  = (cnt_inc > limit);

  logic [ACC_W-1:0] sum_ext, run_ext, target_ext;
  logic [ACC_W-1:0] in_fit_ext, rd_fit_ext, hit_fit_ext;

  assign sum_ext     = {{(ACC_W-SUM_W){1'b0}}, fitness_sum};
  assign run_ext     = {{(ACC_W-SUM_W){1'b0}}, run};
  assign target_ext  = {{(ACC_W-SUM_W){1'b0}}, target};
  assign in_fit_ext  = {{(ACC_W-FITNESS_BITS){1'b0}}, fitness};
  assign rd_fit_ext  = {{(ACC_W-FITNESS_BITS){1'b0}}, rd_fit};
  assign hit_fit_ext = {{(ACC_W-FITNESS_BITS){1'b0}}, hit_fit};

  // --------------------------------------------------------------------------
  // Sequencer: next state and unit controls
  // --------------------------------------------------------------------------
  always_comb begin
    state_next = state;
    alu_op     = rsq_pkg::ALU_ADD;
    alu_a      = sum_ext;
    alu_b      = in_fit_ext;
    mem_we     = 1'b0;
    mem_waddr  = entry_count[IDX_W-1:0];
    mem_wdata  = {1'b1, {PICK_W{1'b0}}, fitness};
    mem_re     = 1'b0;
    mem_raddr  = ridx[IDX_W-1:0];
    hit        = 1'b0;
    case (state)
      rsq_pkg::ST_IDLE: begin
        // load: append at the fill count, sum += fitness
        if (accept) begin
          if (in_cmd == rsq_pkg::CMD_DRAW) begin
            state_next = rsq_pkg::ST_MUL;
          end else begin
            state_next = rsq_pkg::ST_RESP;
          end
          if (load_ok) begin
            mem_we = 1'b1;
          end
        end
      end
      rsq_pkg::ST_MUL: begin
        // acc = 2*acc + bit * sum
        alu_a = {acc[ACC_W-2:0], 1'b0};
        alu_b = frac_r[mcnt] ? sum_ext : '0;
        if (mcnt == '0) begin
          state_next = rsq_pkg::ST_SCAN;
        end
      end
      rsq_pkg::ST_SCAN: begin
        // check entry didx while the next address is read
        alu_a = run_ext;
        alu_b = rd_fit_ext;
        hit   = dv && rd_active && (alu_y >= target_ext);
        if (hit) begin
          state_next = rsq_pkg::ST_UPD;
        end else if (more) begin
          mem_re = 1'b1;
        end else if (!dv) begin
          state_next = rsq_pkg::ST_RESP;   // nothing active reached the target
        end
      end
      rsq_pkg::ST_UPD: begin
        alu_op     = rsq_pkg::ALU_SUB;
        alu_b      = hit_fit_ext;
        mem_we     = 1'b1;
        mem_waddr  = hit_idx;
        mem_wdata  = {!retire, cnt_inc[PICK_W-1:0], hit_fit};
        state_next = rsq_pkg::ST_RESP;
      end
      rsq_pkg::ST_RESP: begin
        if (out_slot) begin
          state_next = rsq_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = rsq_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= rsq_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // --------------------------------------------------------------------------
  // Control registers
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      quota       <= '0;
      entry_count <= '0;
      fitness_sum <= '0;
      dv          <= 1'b0;
      out_valid   <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        quota <= pick_quota;
      end
      // output register: refill on handoff, else drop once taken
      if (state == rsq_pkg::ST_RESP && out_slot) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        rsq_pkg::ST_IDLE: begin
          if (accept) begin
            case (in_cmd)
              rsq_pkg::CMD_CLEAR: begin
                entry_count <= '0;
                fitness_sum <= '0;
              end
              rsq_pkg::CMD_LOAD: begin
                if (!full) begin
                  entry_count <= entry_count + CNT_W'(1);
                  fitness_sum <= alu_y[SUM_W-1:0];
                end
              end
              default: begin
              end
            endcase
          end
        end
        rsq_pkg::ST_MUL: begin
          if (mcnt == '0) begin
            dv <= 1'b0;
          end
        end
        rsq_pkg::ST_SCAN: begin
          if (!hit) begin
            dv <= more;
          end
        end
        rsq_pkg::ST_UPD: begin
          if (retire) begin
            fitness_sum <= alu_y[SUM_W-1:0];
          end
        end
        default: begin
        end
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Datapath registers
  // --------------------------------------------------------------------------
  logic [rsq_pkg::SEL_W+IDX_W-1:0] sel_wide;

  assign sel_wide = {{rsq_pkg::SEL_W{1'b0}}, res_idx};

  always_ff @(posedge clk) begin
    case (state)
      rsq_pkg::ST_IDLE: begin
        if (accept) begin
          frac_r    <= random_fraction;
          acc       <= '0;
          mcnt      <= MC_W'(RANDOM_BITS - 1);
          res_idx   <= load_ok ? entry_count[IDX_W-1:0] : '0;
          res_valid <= load_ok;
          res_ret   <= 1'b0;
          res_full  <= (in_cmd == rsq_pkg::CMD_LOAD) && full;
        end
      end
      rsq_pkg::ST_MUL: begin
        acc  <= alu_y;
        mcnt <= mcnt - MC_W'(1);
        if (mcnt == '0) begin
          target <= alu_y[ACC_W-1:RANDOM_BITS];
          ridx   <= '0;
          run    <= '0;
        end
      end
      rsq_pkg::ST_SCAN: begin
        if (hit) begin
          hit_idx <= didx;
          hit_cnt <= rd_cnt;
          hit_fit <= rd_fit;
        end else begin
          if (dv && rd_active) begin
            run <= alu_y[SUM_W-1:0];
          end
          if (more) begin
            ridx <= ridx + CNT_W'(1);
            didx <= ridx[IDX_W-1:0];
          end
        end
      end
      rsq_pkg::ST_UPD: begin
        res_idx   <= hit_idx;
        res_valid <= 1'b1;
        res_ret   <= retire;
        res_full  <= 1'b0;
      end
      rsq_pkg::ST_RESP: begin
        if (out_slot) begin
          selected_index <= sel_wide[rsq_pkg::SEL_W-1:0];
          selected_valid <= res_valid;
          entry_retired  <= res_ret;
          table_full     <= res_full;
        end
      end
      default: begin
      end
    endcase
  end

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    entry_count <= CNT_W'(MAX_ENTRIES))
    else $error("entry count beyond table depth");

  a_load_append: assert property (@(posedge clk) disable iff (rst)
    (accept && in_cmd == rsq_pkg::CMD_LOAD && !full)
    |=> entry_count == $past(entry_count) + CNT_W'(1))
    else $error("load did not advance the fill count");

  a_scan_in_fill: assert property (@(posedge clk) disable iff (rst)
    (state == rsq_pkg::ST_SCAN && dv) |-> ({1'b0, didx} < {1'b0, entry_count}))
    else $error("scan read past the fill count");

  a_retire_valid: assert property (@(posedge clk) disable iff (rst)
    (out_valid && entry_retired) |-> selected_valid)
    else $error("retire flagged without a selection");

  a_full_invalid: assert property (@(posedge clk) disable iff (rst)
    (out_valid && table_full) |-> !selected_valid && !entry_retired)
    else $error("refused load reported as a selection");

endmodule

// File: tb/roulette_select_with_quota_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// roulette_select_with_quota_tb
// Self-checking bench for the quota-limited roulette selector. Command items
// (clear, load, draw, unused code) go in through a queue-fed driver, and a
// local model of the fitness table predicts every result item. A monitor
// compares the results in order. Both handshakes idle at random, and the
// pick quota is rewritten between phases while the block is idle.
// ----------------------------------------------------------------------------
module roulette_select_with_quota_tb;

  localparam int FIT_W   = rsq_pkg::FITNESS_BITS_DEF;
  localparam int FRAC_W  = rsq_pkg::RANDOM_BITS_DEF;
  localparam int ENTRIES = rsq_pkg::MAX_ENTRIES_DEF;
  localparam int CMD_W   = rsq_pkg::CMD_W;
  localparam int SEL_W   = rsq_pkg::SEL_W;
  localparam int QUOTA_W = rsq_pkg::QUOTA_W;
  localparam int CYCLE_LIMIT = 1_000_000;
  localparam int DRAIN_CYCLES = 100;        // longer than the longest draw
  localparam int PHASE_ITEMS = 175;
  localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;
  localparam logic [FIT_W-1:0] FIT_MAX = {FIT_W{1'b1}};
  localparam logic [FRAC_W-1:0] FRAC_MAX = {FRAC_W{1'b1}};

  typedef struct packed {
    logic [CMD_W-1:0]  op;
    logic [FIT_W-1:0]  fit;
    logic [FRAC_W-1:0] frac;
  } command_t;

  typedef struct packed {
    logic [SEL_W-1:0] idx;
    logic             hit;
    logic             retired;
    logic             full;
  } pick_t;

  // DUT ports; every input starts at a known value
  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 in_valid = 1'b0;
  logic                 in_ready;
  logic [CMD_W-1:0]     cmd = '0;
  logic [FIT_W-1:0]     fitness = '0;
  logic [FRAC_W-1:0]    random_fraction = '0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  logic [SEL_W-1:0]     selected_index;
  logic                 selected_valid;
  logic                 entry_retired;
  logic                 table_full;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [QUOTA_W-1:0]   pick_quota = '0;

  roulette_select_with_quota dut (
    .clk             (clk),
    .rst             (rst),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .cmd             (cmd),
    .fitness         (fitness),
    .random_fraction (random_fraction),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .selected_index  (selected_index),
    .selected_valid  (selected_valid),
    .entry_retired   (entry_retired),
    .table_full      (table_full),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .pick_quota      (pick_quota)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  // --------------------------------------------------------------------------
  // Wheel model: our own copy of the table, counts and running sum.
  // --------------------------------------------------------------------------
  logic [FIT_W-1:0]   wheel_fit [ENTRIES];
  logic [15:0]        wheel_picks [ENTRIES];
  logic               wheel_live [ENTRIES];
  int unsigned        wheel_loaded = 0;
  logic [29:0]        wheel_sum = '0;
  logic [QUOTA_W-1:0] quota_setting = '0;   // reset value of the register

  command_t pending_cmds[$];   // items waiting for the driver
  pick_t    expected_picks[$]; // predicted results, oldest first
  command_t next_cmd;
  pick_t    seen_pick;
  int       mismatches = 0;
  int       cycles = 0;
  bit       calm = 1'b0;       // set for a phase with no idling anywhere

  initial begin
    for (int i = 0; i < ENTRIES; i++) begin
      wheel_fit[i] = '0;
      wheel_picks[i] = '0;
      wheel_live[i] = 1'b0;
    end
  end

  // Applies one accepted command item to the model and returns its result.
  function automatic pick_t predict_selection(logic [CMD_W-1:0] op,
                                              logic [FIT_W-1:0] fit,
                                              logic [FRAC_W-1:0] frac);
    pick_t       res;
    logic [63:0] target;
    logic [63:0] run;
    int unsigned limit;
    bit          found;
    res = '0;
    case (op)
      rsq_pkg::CMD_CLEAR: begin
        for (int i = 0; i < ENTRIES; i++) begin
          wheel_picks[i] = '0;
          wheel_live[i] = 1'b0;
        end
        wheel_loaded = 0;
        wheel_sum = '0;
      end
      rsq_pkg::CMD_LOAD: begin
        if (wheel_loaded < ENTRIES) begin
          wheel_fit[wheel_loaded] = fit;
          wheel_picks[wheel_loaded] = '0;
          wheel_live[wheel_loaded] = 1'b1;
          wheel_sum = wheel_sum + fit;
          res.idx = wheel_loaded[SEL_W-1:0];
          res.hit = 1'b1;
          wheel_loaded++;
        end else begin
          res.full = 1'b1;
        end
      end
      rsq_pkg::CMD_DRAW: begin
        // exact floor(sum * frac / 2^FRAC_W)
        target = (64'(wheel_sum) * 64'(frac)) >> FRAC_W;
        run = '0;
        found = 1'b0;
        limit = (quota_setting != 0) ? quota_setting : wheel_loaded;
        for (int j = 0; j < ENTRIES; j++) begin
          if (!found && j < wheel_loaded && wheel_live[j]) begin
            run = run + wheel_fit[j];
            if (run >= target) begin
              found = 1'b1;
              if (wheel_picks[j] != 16'hFFFF) wheel_picks[j]++;
              if (wheel_picks[j] > limit) begin
                // over quota: entry drops off the wheel
                wheel_live[j] = 1'b0;
                wheel_sum = wheel_sum - wheel_fit[j];
                res.retired = 1'b1;
              end
              res.idx = j[SEL_W-1:0];
              res.hit = 1'b1;
            end
          end
        end
      end
      default: ;  // unused code: no effect, all-zero result
    endcase
    return res;
  endfunction

  // --------------------------------------------------------------------------
  // Driver: presents queued items; valid holds until the item is taken.
  // The prediction is made at the edge that accepts the item.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready)
        expected_picks.push_back(predict_selection(cmd, fitness, random_fraction));
      if (!in_valid || in_ready) begin
        if (pending_cmds.size() != 0 && (calm || $urandom_range(99) >= 33)) begin
          next_cmd = pending_cmds.pop_front();
          in_valid <= 1'b1;
          cmd <= next_cmd.op;
          fitness <= next_cmd.fit;
          random_fraction <= next_cmd.frac;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Monitor: random backpressure, in-order compare against the model.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        seen_pick = pick_t'{selected_index, selected_valid, entry_retired, table_full};
        if (expected_picks.size() == 0) begin
          $display("%0t: unexpected result item idx=%0d valid=%b retired=%b full=%b",
                   $time, seen_pick.idx, seen_pick.hit, seen_pick.retired,
                   seen_pick.full);
          mismatches++;
        end else begin
          if (seen_pick !== expected_picks[0]) begin
            $display("%0t: mismatch: expected idx=%0d valid=%b retired=%b full=%b",
                     $time, expected_picks[0].idx, expected_picks[0].hit,
                     expected_picks[0].retired, expected_picks[0].full);
            $display("%0t:           actual   idx=%0d valid=%b retired=%b full=%b",
                     $time, seen_pick.idx, seen_pick.hit, seen_pick.retired,
                     seen_pick.full);
            mismatches++;
          end
          void'(expected_picks.pop_front());
        end
      end
      out_ready <= calm || ($urandom_range(99) >= 33);
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("%0t: timeout with %0d results outstanding", $time,
               expected_picks.size());
      $display("CHECK FAILED");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus helpers
  // --------------------------------------------------------------------------
  task automatic push_cmd(logic [CMD_W-1:0] op, logic [FIT_W-1:0] fit,
                          logic [FRAC_W-1:0] frac);
    pending_cmds.push_back(command_t'{op, fit, frac});
  endtask

  // Fitness mix: zero, full scale, tiny, and anything.
  function automatic logic [FIT_W-1:0] rand_fitness();
    case ($urandom_range(5))
      0:       return '0;
      1:       return FIT_MAX;
      2:       return FIT_W'($urandom_range(1, 255));
      default: return FIT_W'($urandom);
    endcase
  endfunction

  function automatic logic [FRAC_W-1:0] rand_fraction();
    case ($urandom_range(7))
      0:       return '0;
      1:       return FRAC_MAX;
      default: return FRAC_W'($urandom);
    endcase
  endfunction

  // Waits on the falling edge so the driver's and monitor's updates have settled.
  task automatic wait_drained();
    do @(negedge clk);
    while (pending_cmds.size() != 0 || in_valid || expected_picks.size() != 0);
  endtask

  // Single quota write; only called while the block is idle.
  task automatic write_quota(logic [QUOTA_W-1:0] value);
    @(posedge clk);
    cfg_valid <= 1'b1;
    pick_quota <= value;
    do @(posedge clk);
    while (!cfg_ready);
    cfg_valid <= 1'b0;
    quota_setting = value;
  endtask

  // Queues populations: clear (usually), some loads, then a run of draws.
  // Now and then a large population comes close to filling the table or overflows it; stray
  // loads and unused codes are sprinkled in among the draws.
  task automatic queue_generations(int target_items);
    int added;
    int loads;
    int draws;
    added = 0;
    while (added < target_items) begin
      if ($urandom_range(3) != 0) begin
        push_cmd(rsq_pkg::CMD_CLEAR, rand_fitness(), rand_fraction());
        added++;
      end
      loads = ($urandom_range(9) == 0) ? $urandom_range(60, 66) : $urandom_range(1, 12);
      for (int i = 0; i < loads; i++) begin
        push_cmd(rsq_pkg::CMD_LOAD, rand_fitness(), rand_fraction());
        added++;
      end
      draws = $urandom_range(1, 3 * loads + 4);
      for (int i = 0; i < draws; i++) begin
        case ($urandom_range(19))
          0:       push_cmd(CMD_UNUSED, rand_fitness(), rand_fraction());
          1: begin
            push_cmd(rsq_pkg::CMD_LOAD, rand_fitness(), rand_fraction());
            added++;
          end
          default: begin
            push_cmd(rsq_pkg::CMD_DRAW, rand_fitness(), rand_fraction());
            added++;
          end
        endcase
      end
    end
  endtask

  // --------------------------------------------------------------------------
  // Test sequence
  // --------------------------------------------------------------------------
  logic [QUOTA_W-1:0] quota_plan [8];

  initial begin
    quota_plan = '{7'd1, 7'd64, 7'd0, 7'd127, 7'd2, 7'd65, 7'd3, 7'd0};
    quota_plan[7] = QUOTA_W'($urandom_range(0, 127));
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // Directed part, quota at its reset value (entry count).
    push_cmd(rsq_pkg::CMD_DRAW, FIT_MAX, FRAC_MAX);    // empty table
    push_cmd(CMD_UNUSED, '0, '0);
    push_cmd(rsq_pkg::CMD_LOAD, '0, FRAC_MAX);
    push_cmd(rsq_pkg::CMD_LOAD, '0, '0);
    push_cmd(rsq_pkg::CMD_DRAW, '0, 16'h8000);         // zero sum: first live entry
    push_cmd(rsq_pkg::CMD_LOAD, FIT_MAX, '0);
    push_cmd(rsq_pkg::CMD_LOAD, 24'd1, '0);
    push_cmd(rsq_pkg::CMD_DRAW, '0, '0);
    push_cmd(rsq_pkg::CMD_DRAW, '0, FRAC_MAX);
    push_cmd(rsq_pkg::CMD_DRAW, '0, '0);
    push_cmd(rsq_pkg::CMD_DRAW, '0, '0);
    push_cmd(rsq_pkg::CMD_DRAW, '0, '0);                // entry 0 goes over quota
    push_cmd(rsq_pkg::CMD_LOAD, 24'hAAAAAA, 16'h5555);
    push_cmd(rsq_pkg::CMD_LOAD, 24'h555555, 16'hAAAA);
    push_cmd(rsq_pkg::CMD_DRAW, 24'hFFFFFF, FRAC_MAX);
    push_cmd(rsq_pkg::CMD_DRAW, '0, 16'h0001);
    push_cmd(CMD_UNUSED, FIT_MAX, FRAC_MAX);
    push_cmd(rsq_pkg::CMD_CLEAR, FIT_MAX, FRAC_MAX);
    push_cmd(rsq_pkg::CMD_DRAW, '0, '0);                // just cleared
    push_cmd(rsq_pkg::CMD_LOAD, FIT_MAX, '0);
    push_cmd(rsq_pkg::CMD_DRAW, '0, FRAC_MAX);
    push_cmd(rsq_pkg::CMD_DRAW, '0, 16'h0001);
    push_cmd(rsq_pkg::CMD_CLEAR, '0, '0);
    wait_drained();

    // Random phases, one quota setting each; the third runs with no idling.
    for (int p = 0; p < 8; p++) begin
      write_quota(quota_plan[p]);
      calm = (p == 2);
      queue_generations(PHASE_ITEMS);
      wait_drained();
    end
    calm = 1'b0;

    // Quiet tail: nothing more may show up.
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0 && expected_picks.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

// File: roulette_select_with_quota.f
hw/rtl/rsq_pkg.sv
hw/rtl/rsq_alu.sv
hw/rtl/rsq_table.sv
hw/rtl/roulette_select_with_quota.sv
tb/roulette_select_with_quota_tb.sv
